[design/tcw_pkg.sv]
// Package for the text console writer: geometry constants, action and
// command codes, and the packed transfer types shared by all modules.
// No dependencies.
`default_nettype none
package tcw_pkg;

	localparam int COLS       = 80;
	localparam int LINES      = 25;
	localparam int CELLS      = COLS * LINES;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ACT_PRINT  = 3'd0,
		ACT_SETCUR = 3'd1,
		ACT_CLEAR  = 3'd2,
		ACT_WRITE  = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		CMD_PRINT   = 3'd0,
		CMD_NEWLINE = 3'd1,
		CMD_SETCUR  = 3'd2,
		CMD_CLEAR   = 3'd3,
		CMD_WRITE   = 3'd4,
		CMD_READ    = 3'd5,
		CMD_IGNORE  = 3'd6
	} cmd_op_t;

	typedef struct packed {
		logic [2:0]       action;
		logic [7:0]       character;
		logic [7:0]       attrib;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} item_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
		logic [7:0]       read_char;
		logic [7:0]       read_attr;
		logic             scrolled;
		logic             ignored;
	} result_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [15:0]      cell_data;
		addr_t            addr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cmd_t;

endpackage
`default_nettype wire

[design/tcw_cmd_fifo.sv]
// Short command queue between the front and back of the console writer.
// Depends on tcw_pkg.
`default_nettype none
module tcw_cmd_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tcw_pkg::cmd_t wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output tcw_pkg::cmd_t     rdata
);

	tcw_pkg::cmd_t                     entry_q [tcw_pkg::FIFO_DEPTH];
	logic [tcw_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [tcw_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [tcw_pkg::FIFO_PTR_W:0]      count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == (tcw_pkg::FIFO_PTR_W+1)'(tcw_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wdata;
	end

endmodule
`default_nettype wire

[design/tcw_front.sv]
// Front end of the console writer: takes input transfers, bounds-checks
// and decodes them into commands for the queue. Depends on tcw_pkg.
`default_nettype none
module tcw_front (
	input  wire tcw_pkg::item_t item,
	input  wire logic         push,
	output logic              full,
	input  wire logic         busy,
	input  wire logic         cmd_full,
	output logic              cmd_push,
	output tcw_pkg::cmd_t     cmd
);

	logic in_bounds;

	assign full      = cmd_full || busy;
	assign cmd_push  = push && !full;
	assign in_bounds = (int'(item.col) < tcw_pkg::COLS) && (int'(item.row) < tcw_pkg::LINES);

	always_comb begin
		cmd.cell_data = {item.attrib, item.character};
		cmd.addr = tcw_pkg::addr_t'(item.row) * tcw_pkg::addr_t'(tcw_pkg::COLS)
			+ tcw_pkg::addr_t'(item.col);
		cmd.col  = item.col;
		cmd.row  = item.row;
		case (item.action)
			tcw_pkg::ACT_PRINT:
				cmd.op = (item.character == tcw_pkg::NEWLINE_CODE) ?
					tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PRINT;
			tcw_pkg::ACT_SETCUR:
				cmd.op = in_bounds ? tcw_pkg::CMD_SETCUR : tcw_pkg::CMD_IGNORE;
			tcw_pkg::ACT_CLEAR:
				cmd.op = tcw_pkg::CMD_CLEAR;
			tcw_pkg::ACT_WRITE:
				cmd.op = in_bounds ? tcw_pkg::CMD_WRITE : tcw_pkg::CMD_IGNORE;
			tcw_pkg::ACT_READ:
				cmd.op = in_bounds ? tcw_pkg::CMD_READ : tcw_pkg::CMD_IGNORE;
			default:
				cmd.op = tcw_pkg::CMD_IGNORE;
		endcase
	end

endmodule
`default_nettype wire

[design/tcw_back.sv]
// Back end of the console writer: cell store, cursor, scroll and clear
// sweeps, and the result register. Depends on tcw_pkg.
`default_nettype none
module tcw_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_empty,
	input  wire tcw_pkg::cmd_t cmd,
	output logic              cmd_pop,
	output logic              busy,
	output logic              empty,
	input  wire logic         pop,
	output tcw_pkg::result_t  result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic                         init_q;
	logic                         clear_mode_q;
	logic                         scroll_q;
	tcw_pkg::addr_t               sweep_q;
	logic [tcw_pkg::COL_W-1:0]    cur_col_q;
	logic [tcw_pkg::ROW_W-1:0]    cur_row_q;
	logic                         res_valid_q;
	tcw_pkg::result_t             res_q;

	logic                         wr_valid_s1;
	logic                         wr_zero_s1;
	tcw_pkg::addr_t               wr_addr_s1;

	logic [15:0]                  mem [tcw_pkg::CELLS];
	logic [15:0]                  rdata_q;

	logic                         slot_free;
	logic                         dispatch;
	logic                         last_col;
	logic                         last_row;
	logic                         do_scroll;
	logic                         sweep_copy;
	tcw_pkg::addr_t               cur_addr;
	tcw_pkg::addr_t               rd_addr;
	logic                         we;
	tcw_pkg::addr_t               wa;
	logic [15:0]                  wd;
	logic                         res_load;
	tcw_pkg::result_t             res_next;

	assign busy      = init_q;
	assign empty     = !res_valid_q;
	assign result    = res_q;
	assign slot_free = !res_valid_q || pop;
	assign dispatch  = (state_q == ST_IDLE) && !cmd_empty && slot_free;
	assign cmd_pop   = dispatch;

	assign last_col  = (cur_col_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
	assign last_row  = (cur_row_q == tcw_pkg::ROW_W'(tcw_pkg::LINES - 1));
	assign do_scroll = ((cmd.op == tcw_pkg::CMD_PRINT) && last_col && last_row)
		|| ((cmd.op == tcw_pkg::CMD_NEWLINE) && last_row);
	assign cur_addr  = tcw_pkg::addr_t'(cur_row_q) * tcw_pkg::addr_t'(tcw_pkg::COLS)
		+ tcw_pkg::addr_t'(cur_col_q);

	assign sweep_copy = !clear_mode_q
		&& (sweep_q < tcw_pkg::addr_t'(tcw_pkg::CELLS - tcw_pkg::COLS));
	assign rd_addr    = (state_q == ST_SWEEP) ?
		(sweep_copy ? sweep_q + tcw_pkg::addr_t'(tcw_pkg::COLS) : '0) : cmd.addr;

	always_comb begin
		we = 1'b0;
		wa = cmd.addr;
		wd = cmd.cell_data;
		if (wr_valid_s1) begin
			we = 1'b1;
			wa = wr_addr_s1;
			wd = wr_zero_s1 ? '0 : rdata_q;
		end else if (dispatch && cmd.op == tcw_pkg::CMD_PRINT) begin
			we = 1'b1;
			wa = cur_addr;
		end else if (dispatch && cmd.op == tcw_pkg::CMD_WRITE) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		res_load            = 1'b0;
		res_next.cursor_col = cur_col_q;
		res_next.cursor_row = cur_row_q;
		res_next.read_char  = '0;
		res_next.read_attr  = '0;
		res_next.scrolled   = 1'b0;
		res_next.ignored    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (dispatch) begin
					case (cmd.op)
						tcw_pkg::CMD_PRINT: begin
							res_load = !do_scroll;
							if (last_col) begin
								res_next.cursor_col = '0;
								res_next.cursor_row = cur_row_q + 1'b1;
							end else begin
								res_next.cursor_col = cur_col_q + 1'b1;
							end
						end
						tcw_pkg::CMD_NEWLINE: begin
							res_load = !do_scroll;
							res_next.cursor_col = '0;
							res_next.cursor_row = cur_row_q + 1'b1;
						end
						tcw_pkg::CMD_SETCUR: begin
							res_load = 1'b1;
							res_next.cursor_col = cmd.col;
							res_next.cursor_row = cmd.row;
						end
						tcw_pkg::CMD_WRITE:
							res_load = 1'b1;
						tcw_pkg::CMD_IGNORE: begin
							res_load = 1'b1;
							res_next.ignored = 1'b1;
						end
						default:
							res_load = 1'b0;
					endcase
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_next.read_char = rdata_q[7:0];
				res_next.read_attr = rdata_q[15:8];
			end
			ST_DONE: begin
				res_load = !init_q;
				res_next.scrolled = scroll_q;
			end
			default:
				res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res_next;
		wr_addr_s1 <= sweep_q;
		wr_zero_s1 <= !sweep_copy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			init_q       <= 1'b1;
			clear_mode_q <= 1'b1;
			scroll_q     <= 1'b0;
			sweep_q      <= '0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			res_valid_q  <= 1'b0;
			wr_valid_s1  <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == ST_SWEEP);
			if (res_load)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (dispatch) begin
						case (cmd.op)
							tcw_pkg::CMD_PRINT, tcw_pkg::CMD_NEWLINE: begin
								if (do_scroll) begin
									cur_col_q    <= '0;
									scroll_q     <= 1'b1;
									clear_mode_q <= 1'b0;
									sweep_q      <= '0;
									state_q      <= ST_SWEEP;
								end else begin
									cur_col_q <= res_next.cursor_col;
									cur_row_q <= res_next.cursor_row;
								end
							end
							tcw_pkg::CMD_SETCUR: begin
								cur_col_q <= cmd.col;
								cur_row_q <= cmd.row;
							end
							tcw_pkg::CMD_CLEAR: begin
								cur_col_q    <= '0;
								cur_row_q    <= '0;
								scroll_q     <= 1'b0;
								clear_mode_q <= 1'b1;
								sweep_q      <= '0;
								state_q      <= ST_SWEEP;
							end
							tcw_pkg::CMD_READ:
								state_q <= ST_READ;
							default:
								state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ:
					state_q <= ST_IDLE;
				ST_SWEEP: begin
					if (sweep_q == tcw_pkg::addr_t'(tcw_pkg::CELLS - 1))
						state_q <= ST_DONE;
					else
						sweep_q <= sweep_q + 1'b1;
				end
				ST_DONE: begin
					init_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default:
					state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/text_console_writer.sv]
// Throughput: one item per cycle into the 4-entry command queue while full is low. The
// back end retires a simple item (print, newline, set cursor, write, ignored) per cycle
// while the result slot is free, loading the result register on dispatch; a read loads
// it from the READ state, and a clear or scroll after one cell-store pass.
// Reset: a clearing pass over all CELLS entries holds full high.
// Depends on tcw_pkg, tcw_front, tcw_cmd_fifo and tcw_back.
`default_nettype none
module text_console_writer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire tcw_pkg::item_t item,
	output logic              empty,
	input  wire logic         pop,
	output tcw_pkg::result_t  result
);

	tcw_pkg::cmd_t cmd_in;
	tcw_pkg::cmd_t cmd_out;
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_pop;
	logic          cmd_empty;
	logic          busy;

	tcw_front u_front (
		.item     (item),
		.push     (push),
		.full     (full),
		.busy     (busy),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	tcw_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_out)
	);

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.busy      (busy),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire
